// ----- hw/rtl/n2w_pkg.sv -----
// Shared types, word codes and helper functions for the number-to-words block.
// Used by the front converter, the queue, the word sequencer and the top level.
// No dependencies.
`default_nettype none

package n2w_pkg;

  // Input value and the binary-to-BCD conversion.
  localparam int VALUE_W       = 31;
  localparam int BIN_W         = 32;  // value padded to a whole number of steps
  localparam int NUM_DIGITS    = 10;  // 2147483647 has ten decimal digits
  localparam int BCD_W         = 4 * NUM_DIGITS;
  localparam int DD_W          = BCD_W + BIN_W;
  localparam int STEPS_PER_CYC = 4;
  localparam int CONV_CYCLES   = BIN_W / STEPS_PER_CYC;
  localparam int CNT_W         = $clog2(CONV_CYCLES);
  localparam int NUM_GROUPS    = 4;
  localparam int GI_W          = 2;

  // Stream widths.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;
  localparam int WORD_W      = 5;

  typedef logic [3:0]                 digit_t;
  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;
  typedef logic [DD_W-1:0]            dd_t;
  typedef logic [WORD_W-1:0]          word_t;
  typedef logic [GI_W-1:0]            gidx_t;
  typedef logic [NUM_GROUPS-1:0]      gmask_t;

  typedef struct packed {
    digit_t h;
    digit_t t;
    digit_t u;
  } grp_t;

  // Word codes.
  localparam word_t CODE_ZERO     = 5'd0;
  localparam word_t CODE_TEN      = 5'd10;
  localparam word_t CODE_TENS0    = 5'd18;
  localparam word_t CODE_HUNDRED  = 5'd28;
  localparam word_t CODE_THOUSAND = 5'd29;

  // Word slots of one group, emitted lowest slot first.
  localparam int NUM_SLOTS  = 6;
  localparam int SLOT_HUND  = 0;
  localparam int SLOT_HWORD = 1;
  localparam int SLOT_TENS  = 2;
  localparam int SLOT_UNIT  = 3;
  localparam int SLOT_SCALE = 4;
  localparam int SLOT_ZERO  = 5;

  typedef logic [NUM_SLOTS-1:0] smask_t;

  // One shift-add-3 step of the binary-to-BCD conversion.
  function automatic dd_t dd_step(dd_t x);
    dd_t y;
    y = x;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (y[BIN_W + 4*i +: 4] >= 4'd5) begin
        y[BIN_W + 4*i +: 4] = y[BIN_W + 4*i +: 4] + 4'd3;
      end
    end
    return y << 1;
  endfunction

  // Nonzero flag of each three-digit group.
  function automatic gmask_t grp_nz(bcd_t d);
    gmask_t nz;
    nz[0] = |{d[2], d[1], d[0]};
    nz[1] = |{d[5], d[4], d[3]};
    nz[2] = |{d[8], d[7], d[6]};
    nz[3] = |d[9];
    return nz;
  endfunction

  // Digits of one group; the top group holds only a units digit.
  function automatic grp_t grp_sel(bcd_t d, gidx_t gi);
    grp_t g;
    case (gi)
      2'd0:    g = '{h: d[2], t: d[1], u: d[0]};
      2'd1:    g = '{h: d[5], t: d[4], u: d[3]};
      2'd2:    g = '{h: d[8], t: d[7], u: d[6]};
      default: g = '{h: 4'd0, t: 4'd0, u: d[9]};
    endcase
    return g;
  endfunction

  // Slots that carry a word for a nonzero group.
  function automatic smask_t grp_mask(grp_t g, gidx_t gi);
    smask_t m;
    m             = '0;
    m[SLOT_HUND]  = (g.h != 4'd0);
    m[SLOT_HWORD] = (g.h != 4'd0);
    m[SLOT_TENS]  = (g.t != 4'd0);
    m[SLOT_UNIT]  = (g.t != 4'd1) && (g.u != 4'd0);
    m[SLOT_SCALE] = (gi != 2'd0);
    return m;
  endfunction

  // Highest nonzero group strictly below gi.
  function automatic gidx_t grp_next(gmask_t nz, gidx_t gi);
    gmask_t below;
    gidx_t  n;
    below = nz & ((gmask_t'(1) << gi) - gmask_t'(1));
    n     = '0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (below[i]) begin
        n = gidx_t'(i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/n2w_front.sv -----
// Front end: accepts a value and converts it to ten BCD digits, four bits a cycle.
// Depends on n2w_pkg.
`default_nettype none

module n2w_front
  import n2w_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output bcd_t                       push_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  dd_t              dd_r, dd_nxt;
  dd_t              dd_step4;

  always_comb begin
    dd_step4 = dd_r;
    for (int k = 0; k < STEPS_PER_CYC; k++) begin
      dd_step4 = dd_step(dd_step4);
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign push_valid = (state_r == ST_PUSH);
  assign push_data  = bcd_t'(dd_r[DD_W-1:BIN_W]);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dd_nxt    = dd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          dd_nxt    = {{BCD_W{1'b0}}, 1'b0, in_tdata[VALUE_W-1:0]};
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        dd_nxt  = dd_step4;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CONV_CYCLES - 1)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    dd_r <= dd_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/n2w_fifo.sv -----
// Two-entry queue of converted digit sets between the front end and the sequencer.
// Depends on n2w_pkg.
`default_nettype none

module n2w_fifo
  import n2w_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire bcd_t push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output bcd_t      pop_data
);

  bcd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/n2w_back.sv -----
// Back end: walks the digit groups of one number and emits one word code a cycle while the output is not stalled.
// Depends on n2w_pkg.
`default_nettype none

module n2w_back
  import n2w_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   pop_valid,
  output logic                        pop_ready,
  input  wire bcd_t                   pop_data,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  logic   busy_r, busy_nxt;
  bcd_t   dig_r, dig_nxt;
  gidx_t  gi_r, gi_nxt;
  smask_t mask_r, mask_nxt;
  logic   ov_r, ov_nxt;
  word_t  code_r, code_nxt;
  logic   last_r, last_nxt;

  gmask_t ld_nz, cur_nz;
  gidx_t  ld_gi, nx_gi;
  grp_t   cur_g;
  smask_t pick, rest;
  logic   lower_nz, emit;
  word_t  word;

  assign pop_ready  = !busy_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = {{(OUT_TDATA_W - WORD_W){1'b0}}, code_r};
  assign out_tlast  = last_r;

  // Top nonzero group of an incoming number.
  always_comb begin
    ld_nz = grp_nz(pop_data);
    ld_gi = '0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (ld_nz[i]) begin
        ld_gi = gidx_t'(i);
      end
    end
  end

  // Current group, its word, and what follows it.
  always_comb begin
    cur_nz   = grp_nz(dig_r);
    cur_g    = grp_sel(dig_r, gi_r);
    lower_nz = |(cur_nz & ((gmask_t'(1) << gi_r) - gmask_t'(1)));
    nx_gi    = grp_next(cur_nz, gi_r);
    pick     = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (mask_r[s]) begin
        pick = smask_t'(1) << s;
      end
    end
    rest = mask_r & ~pick;
    word = CODE_ZERO;
    case (1'b1)
      pick[SLOT_HUND]:  word = {1'b0, cur_g.h};
      pick[SLOT_HWORD]: word = CODE_HUNDRED;
      pick[SLOT_TENS]: begin
        if (cur_g.t == 4'd1) begin
          word = CODE_TEN + {1'b0, cur_g.u};
        end else begin
          word = CODE_TENS0 + {1'b0, cur_g.t};
        end
      end
      pick[SLOT_UNIT]:  word = {1'b0, cur_g.u};
      pick[SLOT_SCALE]: word = (CODE_THOUSAND - 5'd1) + {3'b0, gi_r};
      default:          word = CODE_ZERO;
    endcase
  end

  assign emit = busy_r && (!ov_r || out_tready);

  always_comb begin
    busy_nxt = busy_r;
    dig_nxt  = dig_r;
    gi_nxt   = gi_r;
    mask_nxt = mask_r;
    ov_nxt   = ov_r && !out_tready;
    code_nxt = code_r;
    last_nxt = last_r;
    if (!busy_r) begin
      if (pop_valid) begin
        busy_nxt = 1'b1;
        dig_nxt  = pop_data;
        gi_nxt   = ld_gi;
        if (ld_nz == '0) begin
          mask_nxt = smask_t'(1) << SLOT_ZERO;
        end else begin
          mask_nxt = grp_mask(grp_sel(pop_data, ld_gi), ld_gi);
        end
      end
    end else if (emit) begin
      ov_nxt   = 1'b1;
      code_nxt = word;
      last_nxt = (rest == '0) && !lower_nz;
      if (rest != '0) begin
        mask_nxt = rest;
      end else if (lower_nz) begin
        gi_nxt   = nx_gi;
        mask_nxt = grp_mask(grp_sel(dig_r, nx_gi), nx_gi);
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    dig_r  <= dig_nxt;
    gi_r   <= gi_nxt;
    mask_r <= mask_nxt;
    code_r <= code_nxt;
    last_r <= last_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/number_to_word_tokens.sv -----
// Top level of the number-to-words block: front converter, queue and word sequencer.
// Depends on n2w_pkg, n2w_front, n2w_fifo and n2w_back.
`default_nettype none

// Spells a non-negative integer (0 .. 2147483647) as a run of English word codes,
// most significant three-digit group first, with out_tlast on the final word.
// Each item on the input stream yields 1 to 16 result items. The front end turns
// the value into ten BCD digits with a shift-add-3 converter, four bits a cycle,
// through an accept, a conversion and a hand-off state, and takes no new value
// until the previous one is handed off. A two-entry queue holds converted numbers
// so the front keeps working while the back end is busy. The back end emits one
// word per cycle while out_tready allows, through a registered output stage, and
// loads each number before its first word, only once the previous number's last
// word is registered. Zero yields the single word Zero.

module number_to_word_tokens
  import n2w_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [30:0] value, [31] zero fill
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [4:0] word_code, [7:5] zero
  output logic                        out_tlast   // last_word
);

  logic push_valid, push_ready;
  bcd_t push_data;
  logic pop_valid, pop_ready;
  bcd_t pop_data;

  // Convert the accepted value to decimal digits.
  n2w_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Hold converted numbers so either side can stall on its own.
  n2w_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Walk the groups and emit one word per cycle while the output sink is ready.
  n2w_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- dv/number_to_word_checker.sv -----
// Checker for number_to_word_tokens: watches both streams, spells each accepted number
// into word codes and compares every result item against the oldest expected word.
// Depends on n2w_pkg for widths and word codes.
module number_to_word_checker
  import n2w_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  output int                     fail_count,
  output int                     words_due,
  output int                     numbers_in,
  output int                     words_out,
  output int                     full_runs
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    word_t code;
    logic  last;
  } spoken_word_t;

  spoken_word_t due_words[$];
  word_t        spelling[$];

  // Append the words of one three-digit group.
  function automatic void spell_group(int unsigned grp);
    int unsigned hund;
    int unsigned rest;
    hund = grp / 100;
    rest = grp % 100;
    if (hund != 0) begin
      spelling.push_back(word_t'(hund));
      spelling.push_back(CODE_HUNDRED);
    end
    if (rest / 10 == 1) begin
      spelling.push_back(word_t'(rest));
    end else begin
      if (rest >= 20) spelling.push_back(CODE_TENS0 + word_t'(rest / 10));
      if (rest % 10 != 0) spelling.push_back(word_t'(rest % 10));
    end
  endfunction

  // Spell a value most significant group first and queue the words.
  function automatic void spell_number(logic [VALUE_W-1:0] value);
    int unsigned divisor [NUM_GROUPS] = '{1, 1000, 1000000, 1000000000};
    int unsigned v;
    int unsigned grp;
    spoken_word_t w;
    v = value;
    spelling.delete();
    if (v == 0) begin
      spelling.push_back(CODE_ZERO);
    end else begin
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
        grp = (v / divisor[g]) % 1000;
        if (grp != 0) begin
          spell_group(grp);
          if (g > 0) spelling.push_back(CODE_THOUSAND + word_t'(g - 1));
        end
      end
    end
    if (spelling.size() == 16) full_runs++;
    foreach (spelling[i]) begin
      w.code = spelling[i];
      w.last = (i == spelling.size() - 1);
      due_words.push_back(w);
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    spoken_word_t want;
    if (!rst_n) begin
      due_words.delete();
      fail_count = 0;
      numbers_in = 0;
      words_out  = 0;
      full_runs  = 0;
    end else begin
      // Retire a word first; it can never belong to a number taken at this edge.
      if (out_tvalid && out_tready) begin
        words_out++;
        if (due_words.size() == 0) begin
          report_mismatch($sformatf("word %0d with nothing outstanding", out_tdata));
        end else begin
          want = due_words.pop_front();
          if (out_tdata[WORD_W-1:0] !== want.code)
            report_mismatch($sformatf("word %0d: code %0d, expected %0d",
                                      words_out, out_tdata[WORD_W-1:0], want.code));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("word %0d: last %b, expected %b",
                                      words_out, out_tlast, want.last));
          if (out_tdata[OUT_TDATA_W-1:WORD_W] !== '0)
            report_mismatch($sformatf("word %0d: fill bits %b not zero",
                                      words_out, out_tdata[OUT_TDATA_W-1:WORD_W]));
        end
      end
      if (in_tvalid && in_tready) begin
        numbers_in++;
        spell_number(in_tdata[VALUE_W-1:0]);
      end
    end
    words_due <= due_words.size();
  end

endmodule

// ----- dv/number_to_word_tokens_test.sv -----
// Top of the number_to_word_tokens testbench: clock, reset, number stimulus and result sink.
// Instantiates the block and number_to_word_checker; depends on n2w_pkg.
module number_to_word_tokens_test
  import n2w_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 386;
  localparam int CYCLE_LIMIT  = 300000;  // far above the slowest legal run
  localparam int SQUEEZE_AT   = 60;      // item count that triggers the long sink hold-off
  localparam int SQUEEZE_LEN  = 400;
  localparam int DRAIN_AT     = 130;     // item index where the source waits for a full drain
  localparam int STEADY_FROM  = 220;     // no idling on either side in this item window
  localparam int STEADY_TO    = 300;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  logic steady      = 1'b0;
  logic squeezed    = 1'b0;
  int   squeeze_left = 0;
  int   cycles       = 0;

  int fail_count;
  int words_due;
  int numbers_in;
  int words_out;
  int full_runs;

  // Directed values: zero, the teens, round tens and hundreds, every scale word,
  // empty middle groups, the 16-word maximum and the all-ones input.
  int unsigned corner_values [] = '{
    0, 1, 9, 10, 11, 15, 19, 20, 21, 99, 100, 101, 110, 119, 999,
    1000, 1001, 1000000, 1000000000, 1010010010, 2000000000,
    1777777777, 1000000001, 12345678, 2147483647
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  number_to_word_tokens uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [30:0] value, [31] zero fill
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [4:0] word_code, [7:5] zero fill
    .out_tlast  (out_tlast)    // last_word
  );

  number_to_word_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .words_due  (words_due),
    .numbers_in (numbers_in),
    .words_out  (words_out),
    .full_runs  (full_runs)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still outstanding", cycles, words_due);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result sink. Idle about 31% of cycles, except in the steady window; once,
  // hold off for a long stretch so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (squeeze_left != 0) begin
      out_tready   <= 1'b0;
      squeeze_left <= squeeze_left - 1;
    end else if (rst_n && !squeezed && numbers_in >= SQUEEZE_AT) begin
      squeezed     <= 1'b1;
      squeeze_left <= SQUEEZE_LEN;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  // One group of three digits, biased toward the cases that change the spelling.
  function automatic int unsigned pick_group();
    int unsigned g;
    case ($urandom_range(0, 5))
      0: g = 0;
      1: g = $urandom_range(1, 9);
      2: g = $urandom_range(10, 19);
      3: g = $urandom_range(20, 99);
      4: g = $urandom_range(1, 9) * 100 + ($urandom_range(0, 1) ? $urandom_range(10, 19) : 0);
      default: g = $urandom_range(0, 999);
    endcase
    return g;
  endfunction

  // Offer one item; idle first at random, then hold it until it is taken.
  task automatic send_number(logic [VALUE_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, value};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    longint unsigned built;
    logic [VALUE_W-1:0] value;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) send_number(corner_values[i][VALUE_W-1:0]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= STEADY_FROM) && (n <= STEADY_TO);
      if (n == DRAIN_AT) begin
        // Pause the source until every outstanding word has come out.
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0, 1: value = VALUE_W'($urandom());  // whole range, every bit both ways
        2:    value = VALUE_W'(pick_group());
        default: begin
          // Build from groups so zero groups, teens and scale words mix freely.
          built = longint'($urandom_range(0, 2)) * 1000000000
                + longint'(pick_group()) * 1000000
                + longint'(pick_group()) * 1000
                + longint'(pick_group());
          if (built > 64'd2147483647) built = built - 1000000000;
          value = built[VALUE_W-1:0];
        end
      endcase
      send_number(value);
    end
    in_tvalid <= 1'b0;
    steady    <= 1'b0;

    // Drain, then allow the block's latency for any stray word to show up.
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Spelled %0d numbers into %0d word items, %0d of them at the 16-word maximum,",
             numbers_in, words_out, full_runs);
    $display("with a long output hold-off, a full drain pause and a stretch without idling.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
